/* rtl/bptt_pkg.sv */
`timescale 1ns / 1ps

package bptt_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int OP_W    = 2;
    localparam int TAG_W   = 8;
    localparam int DROP_W  = 32;
    localparam int HASH_W  = 64;

    // hash shifts
    localparam int SHIFT_A = 4;
    localparam int SHIFT_B = 17;

    // s_axis_tdata layout
    localparam int IN_OP_LSB    = 0;
    localparam int IN_KEY_LSB   = IN_OP_LSB + OP_W;
    localparam int IN_VALUE_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_USED_W    = IN_VALUE_LSB + VALUE_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // m_axis_tdata layout
    localparam int OUT_HIT_BIT   = VALUE_W;
    localparam int OUT_FAIL_BIT  = VALUE_W + 1;
    localparam int OUT_UNC_BIT   = VALUE_W + 2;
    localparam int OUT_DROP_LSB  = VALUE_W + 3;
    localparam int OUT_USED_W    = OUT_DROP_LSB + DROP_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE = 2'd2;

    typedef struct packed {
        logic load;        // take the accepted request
        logic hash_run;    // advance the home-bucket reduction
        logic probe_init;  // start probing at the home bucket
        logic issue;       // issue one probe read
        logic eval;        // probe data on the read port is valid
        logic commit;      // write back, update status, load result
        logic clear_step;  // clear one table entry
    } bptt_cmd_t;

    typedef struct packed {
        logic clear_last;  // clearing the last entry
        logic hash_done;   // home bucket ready
        logic skip;        // request needs no probing
        logic qualify;     // probe data matches (or is free for set)
        logic out_free;    // result register can take a new result
    } bptt_status_t;

    function automatic logic [HASH_W-1:0] hash64(input logic [KEY_W-1:0] key,
                                                 input logic [HASH_W-1:0] kind);
        hash64 = (key >> SHIFT_A) ^ (key >> SHIFT_B) ^ kind;
    endfunction

endpackage

/* rtl/bptt_ram.sv */
`timescale 1ns / 1ps

module bptt_ram #(
    parameter int WIDTH = 136,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bptt_ctrl.sv */
`timescale 1ns / 1ps

module bptt_ctrl #(
    parameter int PROBE_LIMIT = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  bptt_pkg::bptt_status_t status,
    output bptt_pkg::bptt_cmd_t    cmd
);

    import bptt_pkg::*;

    localparam int CW = $clog2(PROBE_LIMIT + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_COMMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   issue_cnt_reg, issue_cnt_next;
    logic            pending_reg, pending_next;
    logic            all_issued;

    assign all_issued = (issue_cnt_reg == CW'(PROBE_LIMIT));

    always_comb begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        pending_next   = pending_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.hash_run = 1'b1;
                if (status.skip) begin
                    state_next = ST_COMMIT;
                end else if (status.hash_done) begin
                    cmd.probe_init = 1'b1;
                    issue_cnt_next = '0;
                    pending_next   = 1'b0;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // read of one probe overlaps the check of the previous one
                cmd.eval  = pending_reg;
                cmd.issue = !all_issued && !(pending_reg && status.qualify);
                if (cmd.issue) begin
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                pending_next = cmd.issue;
                if (pending_reg && (status.qualify || all_issued)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the result register is free
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            issue_cnt_reg <= '0;
            pending_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pending_reg   <= pending_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

/* rtl/bptt_datapath.sv */
`timescale 1ns / 1ps

module bptt_datapath #(
    parameter int TABLE_ENTRIES = 8192,
    parameter int KIND_BITS     = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [bptt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [bptt_pkg::TAG_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bptt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  bptt_pkg::bptt_cmd_t              cmd,
    output bptt_pkg::bptt_status_t           status
);

    import bptt_pkg::*;

    localparam int  AW      = $clog2(TABLE_ENTRIES);
    localparam int  EW      = KEY_W + KIND_BITS + VALUE_W;
    localparam int  KIND_LSB = KEY_W;
    localparam int  VAL_LSB  = KEY_W + KIND_BITS;
    localparam bit  POW2    = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

    // request fields
    logic [OP_W-1:0]      in_op;
    logic [KEY_W-1:0]     in_key;
    logic [VALUE_W-1:0]   in_value;
    logic [15:0]          in_kind_wide;
    logic [KIND_BITS-1:0] in_kind;

    assign in_op        = s_axis_tdata[IN_OP_LSB +: OP_W];
    assign in_key       = s_axis_tdata[IN_KEY_LSB +: KEY_W];
    assign in_value     = s_axis_tdata[IN_VALUE_LSB +: VALUE_W];
    assign in_kind_wide = {8'd0, s_axis_tuser};
    assign in_kind      = in_kind_wide[KIND_BITS-1:0];

    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KIND_BITS-1:0] kind_reg;
    logic [VALUE_W-1:0]   value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            kind_reg  <= in_kind;
            value_reg <= in_value;
        end
    end

    // home bucket
    logic [AW-1:0] home;

    if (POW2) begin : g_mask
        logic [HASH_W-1:0] hash_full;
        assign hash_full        = hash64(key_reg, HASH_W'(kind_reg));
        assign home             = hash_full[AW-1:0];
        assign status.hash_done = 1'b1;
    end else begin : g_remainder
        // reduce the hash 16 bits at a time, top digit first; each digit goes through
        // three steps: reciprocal estimate, back-multiply, final compare and subtract
        localparam int          DIGIT_W = 16;
        localparam int          DIGITS  = HASH_W / DIGIT_W;
        localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));
        localparam logic [31:0] MODULUS = 32'(TABLE_ENTRIES);

        typedef enum logic [1:0] {
            PH_ESTIMATE,
            PH_BACK,
            PH_FIX
        } phase_t;

        phase_t            phase_reg;
        logic [2:0]        count_reg;
        logic [HASH_W-1:0] digits_reg;
        logic [AW-1:0]     rem_reg;
        logic [31:0]       acc_reg;
        logic [31:0]       quot_reg;
        logic [31:0]       part_reg;
        logic [31:0]       acc_in;
        logic [63:0]       recip_prod;
        logic              done;

        assign done       = (count_reg == 3'(DIGITS));
        assign acc_in     = {16'(rem_reg), digits_reg[HASH_W-1 -: DIGIT_W]};
        assign recip_prod = 64'(acc_in) * 64'(RECIP);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                phase_reg <= PH_ESTIMATE;
                count_reg <= '0;
            end else if (cmd.load) begin
                phase_reg <= PH_ESTIMATE;
                count_reg <= '0;
            end else if (cmd.hash_run && !done) begin
                unique case (phase_reg)
                    PH_ESTIMATE: begin
                        phase_reg <= PH_BACK;
                    end
                    PH_BACK: begin
                        phase_reg <= PH_FIX;
                    end
                    default: begin
                        phase_reg <= PH_ESTIMATE;
                        count_reg <= count_reg + 3'd1;
                    end
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                digits_reg <= hash64(in_key, HASH_W'(in_kind));
                rem_reg    <= '0;
            end else if (cmd.hash_run && !done) begin
                unique case (phase_reg)
                    PH_ESTIMATE: begin
                        acc_reg  <= acc_in;
                        quot_reg <= recip_prod[63:32];
                    end
                    PH_BACK: begin
                        // estimate is at most one short, so this stays below twice the modulus
                        part_reg <= acc_reg - quot_reg * MODULUS;
                    end
                    default: begin
                        rem_reg    <= (part_reg >= MODULUS) ? AW'(part_reg - MODULUS) :
                                                              AW'(part_reg);
                        digits_reg <= {digits_reg[HASH_W-DIGIT_W-1:0], DIGIT_W'(0)};
                    end
                endcase
            end
        end

        assign home             = rem_reg;
        assign status.hash_done = done;
    end

    // probe and clear addressing
    logic [AW-1:0] probe_idx_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] probe_idx_inc;

    assign probe_idx_inc = (probe_idx_reg == AW'(TABLE_ENTRIES - 1)) ?
                           '0 : probe_idx_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.probe_init) begin
            probe_idx_reg <= home;
        end else if (cmd.issue) begin
            probe_idx_reg <= probe_idx_inc;
        end
        if (cmd.issue) begin
            rd_idx_reg <= probe_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_idx_reg <= clr_idx_reg + AW'(1);
        end
    end

    assign status.clear_last = (clr_idx_reg == AW'(TABLE_ENTRIES - 1));

    // table
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic [KEY_W-1:0]     rd_key;
    logic [KIND_BITS-1:0] rd_kind;
    logic [VALUE_W-1:0]   rd_value;

    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign rd_kind  = ram_rdata[KIND_LSB +: KIND_BITS];
    assign rd_value = ram_rdata[VAL_LSB +: VALUE_W];

    logic uncertain_reg;

    assign status.qualify = ((rd_key == key_reg) && (rd_kind == kind_reg)) ||
                            ((op_reg == OP_SET) && (rd_key == '0));

    assign status.skip = (key_reg == '0) ||
                         ((op_reg != OP_SET) && (op_reg != OP_GET) &&
                          (op_reg != OP_ERASE)) ||
                         ((op_reg == OP_GET) && uncertain_reg);

    // first qualifying entry
    logic               found_reg;
    logic [AW-1:0]      found_idx_reg;
    logic [VALUE_W-1:0] found_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (cmd.eval && status.qualify) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval && status.qualify) begin
            found_idx_reg   <= rd_idx_reg;
            found_value_reg <= rd_value;
        end
    end

    logic write_back;
    assign write_back = cmd.commit && found_reg &&
                        ((op_reg == OP_SET) || (op_reg == OP_ERASE));

    always_comb begin
        ram_addr  = probe_idx_reg;
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (cmd.clear_step) begin
            ram_addr = clr_idx_reg;
            ram_we   = 1'b1;
        end else if (cmd.commit) begin
            ram_addr = found_idx_reg;
            ram_we   = write_back;
            // erase keeps key and kind as a tombstone
            ram_wdata = {(op_reg == OP_SET) ? value_reg : VALUE_W'(0), kind_reg, key_reg};
        end
    end

    bptt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sticky status
    logic [DROP_W-1:0] drop_reg;
    logic              fail;
    logic              uncertain_new;
    logic [DROP_W-1:0] drop_new;
    logic [VALUE_W-1:0] result;

    assign fail          = (op_reg == OP_SET) && (key_reg != '0) && !found_reg;
    assign uncertain_new = uncertain_reg || fail;
    assign drop_new      = (fail && (drop_reg != '1)) ? drop_reg + DROP_W'(1) : drop_reg;
    assign result        = !found_reg ? '0 :
                           (op_reg == OP_SET) ? value_reg : found_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uncertain_reg <= 1'b0;
            drop_reg      <= '0;
        end else if (cmd.commit) begin
            uncertain_reg <= uncertain_new;
            drop_reg      <= drop_new;
        end
    end

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, drop_new, uncertain_new, fail,
                             found_reg, result};
        end
    end

    assign status.out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;

endmodule

/* rtl/bounded_probe_tag_table_unit.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: opcode, key, new_value; tuser: tag_kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result_value, hit, insert_failed,
//                                               uncertain, drop_count
//
// Probing: a request ends at its first qualifying probe, or as a miss after PROBE_LIMIT
// probes. Probe reads go one per cycle through the single table port, and the write-back
// takes that port once. Zero keys, unused opcodes and gets once uncertain skip probing.
// A TABLE_ENTRIES that is not a power of two adds a hash reduction, 16 bits at a time.
// Reset: the table is cleared one entry per cycle; s_axis_tready stays low until every
// entry is cleared.
// Stalls: a result waits in the output register while the next request is accepted and
// probed; its write-back holds until that register is free.

module bounded_probe_tag_table_unit #(
    parameter int TABLE_ENTRIES = 8192,
    parameter int PROBE_LIMIT   = 4,
    parameter int KIND_BITS     = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] opcode, [65:2] key, [129:66] new_value, [135:130] zero
    input  logic [bptt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [7:0] tag_kind
    input  logic [bptt_pkg::TAG_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [63:0] result_value, [64] hit, [65] insert_failed, [66] uncertain,
    // [98:67] drop_count, [103:99] zero
    output logic [bptt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import bptt_pkg::*;

    bptt_cmd_t    cmd;
    bptt_status_t status;

    bptt_ctrl #(
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    bptt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KIND_BITS     (KIND_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

/* tb/bounded_probe_tag_table_unit_test.sv */
`timescale 1ns / 1ps

module bounded_probe_tag_table_unit_test;
    import bptt_pkg::*;

    localparam int ENTRIES      = 8192;
    localparam int IDX_W        = 13;
    localparam int PROBES       = 4;
    localparam int TARGETS      = 16;
    localparam int POOL_KEYS    = 5;
    localparam int EARLY_ITEMS  = 800;
    localparam int LATE_ITEMS   = 440;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   kind;
        logic [VALUE_W-1:0] value;
    } tag_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic               failed;
        logic               uncertain;
        logic [DROP_W-1:0]  drops;
    } tag_rsp_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // opcode, key, new_value (lowest bits first)
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // tag_kind
    logic [TAG_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // result_value, hit, insert_failed, uncertain, drop_count (lowest bits first)
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the tag table
    logic [KEY_W-1:0]   shadow_key   [ENTRIES];
    logic [TAG_W-1:0]   shadow_kind  [ENTRIES];
    logic [VALUE_W-1:0] shadow_value [ENTRIES];
    logic               shadow_uncertain;
    logic [DROP_W-1:0]  shadow_drops;

    tag_req_t pending_requests[$];
    tag_rsp_t awaited_results[$];
    tag_req_t noise_entries[$];
    tag_req_t offered;

    logic [KEY_W-1:0] pool_key  [TARGETS][POOL_KEYS];
    logic [TAG_W-1:0] pool_kind [TARGETS][POOL_KEYS];

    int issued_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit tx_idle        = 1'b0;
    bit rx_idle        = 1'b0;
    bit rx_hold_req    = 1'b0;

    bounded_probe_tag_table_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic tag_rsp_t apply_table_request(tag_req_t r);
        tag_rsp_t          o;
        logic [HASH_W-1:0] h;
        logic [IDX_W-1:0]  idx;
        logic              found;
        o = '0;
        found = 1'b0;
        if (r.key != '0 && r.op != OP_NONE) begin
            h = (r.key >> SHIFT_A) ^ (r.key >> SHIFT_B) ^ HASH_W'(r.kind);
            if (r.op == OP_SET) begin
                for (int n = 0; n < PROBES; n++) begin
                    idx = h[IDX_W-1:0] + IDX_W'(n);
                    if (!found && ((shadow_key[idx] == r.key && shadow_kind[idx] == r.kind) ||
                                   shadow_key[idx] == '0)) begin
                        shadow_key[idx]   = r.key;
                        shadow_kind[idx]  = r.kind;
                        shadow_value[idx] = r.value;
                        o.value = r.value;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    o.failed = 1'b1;
                    shadow_uncertain = 1'b1;
                    if (shadow_drops != '1)
                        shadow_drops = shadow_drops + 1'b1;
                end
            end else if (!(r.op == OP_GET && shadow_uncertain)) begin
                // get and erase scan every probe, empty or not
                for (int n = 0; n < PROBES; n++) begin
                    idx = h[IDX_W-1:0] + IDX_W'(n);
                    if (!found && shadow_key[idx] == r.key && shadow_kind[idx] == r.kind) begin
                        o.value = shadow_value[idx];
                        found = 1'b1;
                        if (r.op == OP_ERASE)
                            shadow_value[idx] = '0;
                    end
                end
            end
        end
        o.hit = found;
        o.uncertain = shadow_uncertain;
        o.drops = shadow_drops;
        return o;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_SET;
        if (r < 75)
            return OP_GET;
        return OP_ERASE;
    endfunction

    // pool targets sit far apart so their probe windows never overlap;
    // the last one straddles the end of the table
    function automatic int target_bucket(int t);
        return (t < TARGETS - 1) ? t * 512 + 200 : ENTRIES - 2;
    endfunction

    // random key whose home bucket for this kind is the given one
    function automatic logic [KEY_W-1:0] key_for_bucket(int bucket, logic [TAG_W-1:0] kind);
        logic [KEY_W-1:0] k;
        k = rand_word();
        k[SHIFT_A +: IDX_W] = IDX_W'(bucket) ^ k[SHIFT_B +: IDX_W] ^ IDX_W'(kind);
        if (k == '0)
            k[KEY_W-1] = 1'b1;
        return k;
    endfunction

    task automatic queue_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [TAG_W-1:0] kind, logic [VALUE_W-1:0] value);
        tag_req_t r;
        while (pending_requests.size() > 4)
            @(posedge aclk);
        r.op = op;
        r.key = key;
        r.kind = kind;
        r.value = value;
        pending_requests.push_back(r);
        issued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic pool_request(logic [OP_W-1:0] op, int t, int e);
        queue_request(op, pool_key[t][e], pool_kind[t][e], rand_word());
    endtask

    task automatic gen_random_request(bit late);
        int       r;
        int       t;
        int       e;
        tag_req_t n;
        r = $urandom_range(0, 99);
        n.kind = TAG_W'($urandom_range(0, 255));
        if (r < 4) begin
            queue_request(OP_W'($urandom_range(0, 3)), '0, n.kind, rand_word());
        end else if (r < 7) begin
            queue_request(OP_NONE, rand_word(), n.kind, rand_word());
        end else if (r < 62) begin
            // the fifth pool key would overflow its window: keep it for the late phase
            t = $urandom_range(0, TARGETS - 1);
            e = $urandom_range(0, late ? POOL_KEYS - 1 : POOL_KEYS - 2);
            pool_request(pick_op(), t, e);
        end else if (r < 80 && noise_entries.size() > 0) begin
            n = noise_entries[$urandom_range(0, noise_entries.size() - 1)];
            queue_request(pick_op(), n.key, n.kind, rand_word());
        end else if (r < 92) begin
            n.key = key_for_bucket(512 * $urandom_range(0, 15) + $urandom_range(260, 450), n.kind);
            noise_entries.push_back(n);
            queue_request(OP_SET, n.key, n.kind, rand_word());
        end else if (late) begin
            t = $urandom_range(0, TARGETS - 1);
            queue_request(OP_SET, key_for_bucket(target_bucket(t), n.kind), n.kind, rand_word());
        end else begin
            queue_request(OP_GET, rand_word(), n.kind, rand_word());
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        logic [IN_DATA_W-1:0] word;
        logic                 next_valid;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(apply_table_request(offered));
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                next_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0) begin
                    offered = pending_requests.pop_front();
                    word = '0;
                    word[IN_OP_LSB +: OP_W] = offered.op;
                    word[IN_KEY_LSB +: KEY_W] = offered.key;
                    word[IN_VALUE_LSB +: VALUE_W] = offered.value;
                    s_axis_tdata <= word;
                    s_axis_tuser <= offered.kind;
                    next_valid = 1'b1;
                    send_gap = tx_idle ? idle_gap() : 0;
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        tag_rsp_t seen;
        tag_rsp_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.value = m_axis_tdata[VALUE_W-1:0];
                seen.hit = m_axis_tdata[OUT_HIT_BIT];
                seen.failed = m_axis_tdata[OUT_FAIL_BIT];
                seen.uncertain = m_axis_tdata[OUT_UNC_BIT];
                seen.drops = m_axis_tdata[OUT_DROP_LSB +: DROP_W];
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding: value 0x%0h", seen.value);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_value", want.value, seen.value);
                    check_field("hit", 64'(want.hit), 64'(seen.hit));
                    check_field("insert_failed", 64'(want.failed), 64'(seen.failed));
                    check_field("uncertain", 64'(want.uncertain), 64'(seen.uncertain));
                    check_field("drop_count", 64'(want.drops), 64'(seen.drops));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = rx_idle ? idle_gap() : 0;
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    initial begin
        int b;
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i] = '0;
            shadow_kind[i] = '0;
            shadow_value[i] = '0;
        end
        shadow_uncertain = 1'b0;
        shadow_drops = '0;

        // four keys per target fill its window exactly; the second shares the
        // first key with a neighboring kind, so its home is one bucket up
        for (int t = 0; t < TARGETS; t++) begin
            b = target_bucket(t);
            for (int e = 0; e < POOL_KEYS; e++)
                pool_kind[t][e] = TAG_W'($urandom_range(0, 255));
            pool_kind[t][1] = pool_kind[t][0] ^ 8'h01;
            for (int e = 0; e < POOL_KEYS; e++)
                pool_key[t][e] = key_for_bucket(b, pool_kind[t][e]);
            pool_key[t][1] = pool_key[t][0];
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // field extremes and a same key under a different kind
        queue_request(OP_SET, '1, '1, '1);
        queue_request(OP_GET, '1, '1, '0);
        queue_request(OP_GET, '1, 8'hFE, '0);
        // zero key and the unused opcode change nothing
        queue_request(OP_SET, '0, 8'h5A, rand_word());
        queue_request(OP_GET, '0, 8'h00, '0);
        queue_request(OP_ERASE, '0, 8'hFF, '1);
        queue_request(OP_NONE, pool_key[0][0], pool_kind[0][0], rand_word());
        // fill one window, probe deep, erase, read and reclaim a tombstone
        pool_request(OP_SET, 0, 0);
        pool_request(OP_SET, 0, 2);
        pool_request(OP_SET, 0, 3);
        pool_request(OP_SET, 0, 1);
        pool_request(OP_GET, 0, 1);
        pool_request(OP_GET, 0, 3);
        pool_request(OP_ERASE, 0, 2);
        pool_request(OP_GET, 0, 2);
        pool_request(OP_SET, 0, 2);
        pool_request(OP_ERASE, 0, 4);
        // window that wraps past the end of the table
        pool_request(OP_SET, TARGETS - 1, 0);
        pool_request(OP_SET, TARGETS - 1, 2);
        pool_request(OP_SET, TARGETS - 1, 3);
        pool_request(OP_SET, TARGETS - 1, 1);
        pool_request(OP_GET, TARGETS - 1, 1);

        for (int i = 0; i < EARLY_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            // keep offering while the result side holds off
            if (i == 300) begin
                tx_idle = 1'b0;
                rx_hold_req = 1'b1;
            end
            gen_random_request(1'b0);
        end

        // hold the sender until every result is back
        wait_drained();

        // overflow a full window: sticky flag, gets answer zero, set and erase still work
        pool_request(OP_SET, 0, 4);
        pool_request(OP_SET, 0, 4);
        pool_request(OP_GET, 0, 0);
        pool_request(OP_ERASE, 0, 0);
        pool_request(OP_SET, 0, 0);
        queue_request(OP_GET, '0, 8'h00, '0);

        for (int i = 0; i < LATE_ITEMS; i++) begin
            if (i % 100 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            gen_random_request(1'b1);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/bptt_pkg.sv
rtl/bptt_ram.sv
rtl/bptt_ctrl.sv
rtl/bptt_datapath.sv
rtl/bounded_probe_tag_table_unit.sv
tb/bounded_probe_tag_table_unit_test.sv
